[sv/film_develop_pixel_step_defines.svh]
// Assertion macros used by the RTL file film_develop_pixel_step.sv.
`ifndef FILM_DEVELOP_PIXEL_STEP_DEFINES_SVH
`define FILM_DEVELOP_PIXEL_STEP_DEFINES_SVH

`ifndef SYNTH
// Checked while out of reset.
`define FDPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked also during reset.
`define FDPS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FDPS_ASSERT(label, prop, msg)
`define FDPS_ASSERT_RST(label, prop, msg)
`endif

`endif

[sv/fdps_pkg.sv]
package fdps_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned NUM_LAYERS    = 3;
  localparam int unsigned FIELD_W       = 24;
  localparam int unsigned GAIN_W        = 32;
  localparam int unsigned CFG_IDX_W     = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GROWTH_GAIN    = 2'd0,
    REG_DEVELOPER_GAIN = 2'd1,
    REG_SALT_GAIN      = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic        [FIELD_W-1:0] developer_level;
    logic signed [FIELD_W-1:0] salt_red;
    logic signed [FIELD_W-1:0] salt_green;
    logic signed [FIELD_W-1:0] salt_blue;
    logic        [FIELD_W-1:0] radius_red;
    logic        [FIELD_W-1:0] radius_green;
    logic        [FIELD_W-1:0] radius_blue;
    logic        [FIELD_W-1:0] crystals_red;
    logic        [FIELD_W-1:0] crystals_green;
    logic        [FIELD_W-1:0] crystals_blue;
  } pix_t;

  typedef struct packed {
    logic        [FIELD_W-1:0] new_developer_level;
    logic signed [FIELD_W-1:0] new_salt_red;
    logic signed [FIELD_W-1:0] new_salt_green;
    logic signed [FIELD_W-1:0] new_salt_blue;
    logic        [FIELD_W-1:0] new_radius_red;
    logic        [FIELD_W-1:0] new_radius_green;
    logic        [FIELD_W-1:0] new_radius_blue;
  } res_t;

endpackage

[sv/film_develop_pixel_step.sv]
// An accepted pixel request moves to its result through one register per stage.
// Throughput: one pixel per cycle while the output is not stalled; each of the five chained products, the gain
// products and the final clamp sit in stages of their own, at most one 33x33 multiply per stage and lane.
// Stalls back up stage by stage; empty stages keep filling while the output waits.
// Reset (rst, synchronous, active high) clears all stage valid bits and the three gains.
`include "film_develop_pixel_step_defines.svh"

module film_develop_pixel_step #(
  parameter int unsigned FRAC_BITS = fdps_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // pixel requests
  input  logic                             pix_valid,
  output logic                             pix_ready,
  input  fdps_pkg::pix_t                   pix,
  // results
  output logic                             res_valid,
  input  logic                             res_ready,
  output fdps_pkg::res_t                   res,
  // register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fdps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fdps_pkg::GAIN_W-1:0]      cfg_data
);

  localparam int unsigned NSTG = 8;
  localparam int unsigned NL   = fdps_pkg::NUM_LAYERS;
  localparam int unsigned FW   = fdps_pkg::FIELD_W;

  // 32-bit signed saturation bounds on the shifted product
  localparam logic signed [64:0] Q_MAX = 65'sd2147483647;
  localparam logic signed [64:0] Q_MIN = -65'sd2147483648;

  // Fixed-point product: exact signed a * unsigned b, floor shift by FRAC_BITS,
  // saturate to signed 32 bits.
  function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                              input logic [31:0] b);
    logic signed [32:0] as;
    logic signed [32:0] bs;
    logic signed [64:0] p;
    logic signed [64:0] q;
    as = {a[31], a};
    bs = {1'b0, b};
    p  = as * bs;
    q  = p >>> FRAC_BITS;
    if (q > Q_MAX)      mulq = 32'sh7FFF_FFFF;
    else if (q < Q_MIN) mulq = 32'sh8000_0000;
    else                mulq = q[31:0];
  endfunction

  function automatic logic [FW-1:0] sat_u24(input logic signed [33:0] v);
    if (v < 34'sd0)             sat_u24 = '0;
    else if (v > 34'sd16777215) sat_u24 = '1;
    else                        sat_u24 = v[FW-1:0];
  endfunction

  function automatic logic signed [FW-1:0] sat_s24(input logic signed [33:0] v);
    if (v < -34'sd8388608)     sat_s24 = 24'sh80_0000;
    else if (v > 34'sd8388607) sat_s24 = 24'sh7F_FFFF;
    else                       sat_s24 = v[FW-1:0];
  endfunction

  function automatic logic signed [31:0] sat_s32(input logic signed [33:0] v);
    if (v < -34'sd2147483648)     sat_s32 = 32'sh8000_0000;
    else if (v > 34'sd2147483647) sat_s32 = 32'sh7FFF_FFFF;
    else                          sat_s32 = v[31:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Gain registers. The user must write them only while the pipe is empty; the block does not enforce it.
  // ---------------------------------------------------------------------------
  logic [fdps_pkg::GAIN_W-1:0] growth_gain;
  logic [fdps_pkg::GAIN_W-1:0] developer_gain;
  logic [fdps_pkg::GAIN_W-1:0] salt_gain;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      growth_gain    <= '0;
      developer_gain <= '0;
      salt_gain      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fdps_pkg::REG_GROWTH_GAIN:    growth_gain    <= cfg_data;
        fdps_pkg::REG_DEVELOPER_GAIN: developer_gain <= cfg_data;
        fdps_pkg::REG_SALT_GAIN:      salt_gain      <= cfg_data;
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Valid / load chain. vld[k] is stage k+1. A stage loads when it is empty or
  // the stage after it loads, so bubbles close up under a stalled output.
  // ---------------------------------------------------------------------------
  logic [NSTG-1:0] vld;
  logic [NSTG:0]   ld;

  always_comb begin
    ld[NSTG] = res_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      ld[k] = !vld[k] || ld[k+1];
    end
  end

  assign pix_ready = ld[0];
  assign res_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) vld[0] <= pix_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (ld[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  logic        [FW-1:0] in_salt_u [NL];
  logic        [FW-1:0] in_rad    [NL];
  logic        [FW-1:0] in_cry    [NL];

  assign in_salt_u[0] = pix.salt_red;
  assign in_salt_u[1] = pix.salt_green;
  assign in_salt_u[2] = pix.salt_blue;
  assign in_rad[0]    = pix.radius_red;
  assign in_rad[1]    = pix.radius_green;
  assign in_rad[2]    = pix.radius_blue;
  assign in_cry[0]    = pix.crystals_red;
  assign in_cry[1]    = pix.crystals_green;
  assign in_cry[2]    = pix.crystals_blue;

  // stage 1: t = salt * developer
  logic signed [31:0]   s1_t    [NL];
  logic        [FW-1:0] s1_dev;
  logic signed [FW-1:0] s1_salt [NL];
  logic        [FW-1:0] s1_rad  [NL];
  logic        [FW-1:0] s1_cry  [NL];
  // stage 2: dr = t * growth_gain
  logic signed [31:0]   s2_dr   [NL];
  logic        [FW-1:0] s2_dev;
  logic signed [FW-1:0] s2_salt [NL];
  logic        [FW-1:0] s2_rad  [NL];
  logic        [FW-1:0] s2_cry  [NL];
  // stage 3: v = dr * radius, new radius
  logic signed [31:0]   s3_v    [NL];
  logic        [FW-1:0] s3_dev;
  logic signed [FW-1:0] s3_salt [NL];
  logic        [FW-1:0] s3_rad  [NL];
  logic        [FW-1:0] s3_cry  [NL];
  logic        [FW-1:0] s3_nrad [NL];
  // stage 4: v = v * radius
  logic signed [31:0]   s4_v    [NL];
  logic        [FW-1:0] s4_dev;
  logic signed [FW-1:0] s4_salt [NL];
  logic        [FW-1:0] s4_cry  [NL];
  logic        [FW-1:0] s4_nrad [NL];
  // stage 5: dv = v * crystals
  logic signed [31:0]   s5_dv   [NL];
  logic        [FW-1:0] s5_dev;
  logic signed [FW-1:0] s5_salt [NL];
  logic        [FW-1:0] s5_nrad [NL];
  // stage 6: summed dv, per-layer salt use
  logic signed [31:0]   s6_sum;
  logic signed [31:0]   s6_ds   [NL];
  logic        [FW-1:0] s6_dev;
  logic signed [FW-1:0] s6_salt [NL];
  logic        [FW-1:0] s6_nrad [NL];
  // stage 7: developer use, new salt
  logic signed [31:0]   s7_cons;
  logic        [FW-1:0] s7_dev;
  logic signed [FW-1:0] s7_nsalt [NL];
  logic        [FW-1:0] s7_nrad  [NL];

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s1_dev <= pix.developer_level;
      for (int i = 0; i < NL; i++) begin
        s1_t[i]    <= mulq({{8{in_salt_u[i][FW-1]}}, in_salt_u[i]},
                           {8'd0, pix.developer_level});
        s1_salt[i] <= in_salt_u[i];
        s1_rad[i]  <= in_rad[i];
        s1_cry[i]  <= in_cry[i];
      end
    end
    if (ld[1]) begin
      s2_dev <= s1_dev;
      for (int i = 0; i < NL; i++) begin
        s2_dr[i]   <= mulq(s1_t[i], growth_gain);
        s2_salt[i] <= s1_salt[i];
        s2_rad[i]  <= s1_rad[i];
        s2_cry[i]  <= s1_cry[i];
      end
    end
    if (ld[2]) begin
      s3_dev <= s2_dev;
      for (int i = 0; i < NL; i++) begin
        s3_v[i]    <= mulq(s2_dr[i], {8'd0, s2_rad[i]});
        s3_nrad[i] <= sat_u24($signed({10'd0, s2_rad[i]}) +
                              $signed({{2{s2_dr[i][31]}}, s2_dr[i]}));
        s3_salt[i] <= s2_salt[i];
        s3_rad[i]  <= s2_rad[i];
        s3_cry[i]  <= s2_cry[i];
      end
    end
    if (ld[3]) begin
      s4_dev <= s3_dev;
      for (int i = 0; i < NL; i++) begin
        s4_v[i]    <= mulq(s3_v[i], {8'd0, s3_rad[i]});
        s4_salt[i] <= s3_salt[i];
        s4_cry[i]  <= s3_cry[i];
        s4_nrad[i] <= s3_nrad[i];
      end
    end
    if (ld[4]) begin
      s5_dev <= s4_dev;
      for (int i = 0; i < NL; i++) begin
        s5_dv[i]   <= mulq(s4_v[i], {8'd0, s4_cry[i]});
        s5_salt[i] <= s4_salt[i];
        s5_nrad[i] <= s4_nrad[i];
      end
    end
    if (ld[5]) begin
      s6_dev <= s5_dev;
      s6_sum <= sat_s32($signed({{2{s5_dv[0][31]}}, s5_dv[0]}) +
                        $signed({{2{s5_dv[1][31]}}, s5_dv[1]}) +
                        $signed({{2{s5_dv[2][31]}}, s5_dv[2]}));
      for (int i = 0; i < NL; i++) begin
        s6_ds[i]   <= mulq(s5_dv[i], salt_gain);
        s6_salt[i] <= s5_salt[i];
        s6_nrad[i] <= s5_nrad[i];
      end
    end
    if (ld[6]) begin
      s7_dev  <= s6_dev;
      s7_cons <= mulq(s6_sum, developer_gain);
      for (int i = 0; i < NL; i++) begin
        s7_nsalt[i] <= sat_s24($signed({{10{s6_salt[i][FW-1]}}, s6_salt[i]}) -
                               $signed({{2{s6_ds[i][31]}}, s6_ds[i]}));
        s7_nrad[i]  <= s6_nrad[i];
      end
    end
    // stage 8: developer clamp into the output register
    if (ld[7]) begin
      res.new_developer_level <= sat_u24($signed({10'd0, s7_dev}) -
                                         $signed({{2{s7_cons[31]}}, s7_cons}));
      res.new_salt_red        <= s7_nsalt[0];
      res.new_salt_green      <= s7_nsalt[1];
      res.new_salt_blue       <= s7_nsalt[2];
      res.new_radius_red      <= s7_nrad[0];
      res.new_radius_green    <= s7_nrad[1];
      res.new_radius_blue     <= s7_nrad[2];
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `FDPS_ASSERT_RST(a_reset_empties, rst |=> !res_valid && (vld == '0), "pipe not empty after reset")
  `FDPS_ASSERT(a_accept_enters, (pix_valid && pix_ready) |=> vld[0], "accepted request not in stage 1")
  `FDPS_ASSERT(a_mid_stall_holds, (vld[3] && !ld[4]) |=> (vld[3] && $stable(s4_v[0]) && $stable(s4_dev)), "stalled stage 4 lost or changed")
  `FDPS_ASSERT(a_no_bubble_stall, (!vld[2] && vld[1]) |-> ld[1], "stage 2 blocked by an empty stage 3")

endmodule

[tb/tb_film_develop_pixel_step.sv]
`timescale 1ns / 1ps

module tb_film_develop_pixel_step;

  localparam int unsigned FRAC      = fdps_pkg::FRAC_BITS_DEF;
  // Pipeline depth of the block
  localparam int unsigned LATENCY   = 8;
  // Receiver hold-off long enough to back the pipe up into the pixel port
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned LIMIT     = 200000;
  localparam int unsigned PHASES    = 7;
  localparam int unsigned PHASE_PIX = 80;

  // Index past the register file; writes to it must be dropped
  localparam logic [fdps_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;
  localparam logic [fdps_pkg::GAIN_W-1:0]    GAIN_ONE = 32'h0001_0000;

  localparam longint          S32_MAX   = 64'sh7FFF_FFFF;
  localparam longint          S32_MIN   = -S32_MAX - 1;
  localparam longint          SALT_MAX  = 64'sh7F_FFFF;
  localparam longint          SALT_MIN  = -SALT_MAX - 1;
  localparam longint          LEVEL_MAX = 64'shFF_FFFF;
  localparam longint unsigned FRAC_MASK = (64'd1 << FRAC) - 1;

  // Bit-exact prediction of one development step plus the in-order result check.
  class film_step_scoreboard;
    logic [fdps_pkg::GAIN_W-1:0] growth_gain;
    logic [fdps_pkg::GAIN_W-1:0] developer_gain;
    logic [fdps_pkg::GAIN_W-1:0] salt_gain;
    fdps_pkg::res_t              step_q[$];
    int                          errors;

    function new();
      growth_gain    = '0;
      developer_gain = '0;
      salt_gain      = '0;
      errors         = 0;
    endfunction

    function void write_reg(logic [fdps_pkg::CFG_IDX_W-1:0] idx,
                            logic [fdps_pkg::GAIN_W-1:0] data);
      case (idx)
        fdps_pkg::REG_GROWTH_GAIN:    growth_gain    = data;
        fdps_pkg::REG_DEVELOPER_GAIN: developer_gain = data;
        fdps_pkg::REG_SALT_GAIN:      salt_gain      = data;
        default: ;
      endcase
    endfunction

    // a*b >> FRAC, floored, clipped to signed 32 bits
    function longint qmul(longint a, longint unsigned b);
      longint unsigned mag;
      longint unsigned prod;
      longint unsigned q;
      mag  = (a < 0) ? -a : a;
      prod = mag * b;
      if (a < 0) begin
        q = (prod >> FRAC) + (((prod & FRAC_MASK) != 0) ? 64'd1 : 64'd0);
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        return -longint'(q);
      end
      q = prod >> FRAC;
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return longint'(q);
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function fdps_pkg::res_t develop(fdps_pkg::pix_t p);
      longint          salt [3];
      longint unsigned rad  [3];
      longint unsigned cry  [3];
      longint          dv   [3];
      longint          nrad [3];
      longint          nsalt[3];
      longint          dev, t, dr, v, sum, cons, nd;
      fdps_pkg::res_t  r;
      dev     = longint'({40'd0, p.developer_level});
      salt[0] = longint'($signed(p.salt_red));
      salt[1] = longint'($signed(p.salt_green));
      salt[2] = longint'($signed(p.salt_blue));
      rad[0]  = {40'd0, p.radius_red};
      rad[1]  = {40'd0, p.radius_green};
      rad[2]  = {40'd0, p.radius_blue};
      cry[0]  = {40'd0, p.crystals_red};
      cry[1]  = {40'd0, p.crystals_green};
      cry[2]  = {40'd0, p.crystals_blue};
      for (int i = 0; i < 3; i++) begin
        t       = qmul(salt[i], dev);
        dr      = qmul(t, {32'd0, growth_gain});
        v       = qmul(dr, rad[i]);
        v       = qmul(v, rad[i]);
        dv[i]   = qmul(v, cry[i]);
        nrad[i] = clip(longint'(rad[i]) + dr, 0, LEVEL_MAX);
      end
      sum  = clip(dv[0] + dv[1] + dv[2], S32_MIN, S32_MAX);
      cons = qmul(sum, {32'd0, developer_gain});
      nd   = clip(dev - cons, 0, LEVEL_MAX);
      for (int i = 0; i < 3; i++)
        nsalt[i] = clip(salt[i] - qmul(dv[i], {32'd0, salt_gain}), SALT_MIN, SALT_MAX);
      r.new_developer_level = nd[fdps_pkg::FIELD_W-1:0];
      r.new_salt_red        = nsalt[0][fdps_pkg::FIELD_W-1:0];
      r.new_salt_green      = nsalt[1][fdps_pkg::FIELD_W-1:0];
      r.new_salt_blue       = nsalt[2][fdps_pkg::FIELD_W-1:0];
      r.new_radius_red      = nrad[0][fdps_pkg::FIELD_W-1:0];
      r.new_radius_green    = nrad[1][fdps_pkg::FIELD_W-1:0];
      r.new_radius_blue     = nrad[2][fdps_pkg::FIELD_W-1:0];
      return r;
    endfunction

    function void note_pixel(fdps_pkg::pix_t p);
      step_q.push_back(develop(p));
    endfunction

    function int pending();
      return step_q.size();
    endfunction

    function void field_check(string name, logic [fdps_pkg::FIELD_W-1:0] want,
                              logic [fdps_pkg::FIELD_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(fdps_pkg::res_t got);
      fdps_pkg::res_t want;
      if (step_q.size() == 0) begin
        errors++;
        $display("%0t: result with no pixel outstanding: expected none, actual %h", $time, got);
        return;
      end
      want = step_q.pop_front();
      field_check("new_developer_level", want.new_developer_level, got.new_developer_level);
      field_check("new_salt_red",        want.new_salt_red,        got.new_salt_red);
      field_check("new_salt_green",      want.new_salt_green,      got.new_salt_green);
      field_check("new_salt_blue",       want.new_salt_blue,       got.new_salt_blue);
      field_check("new_radius_red",      want.new_radius_red,      got.new_radius_red);
      field_check("new_radius_green",    want.new_radius_green,    got.new_radius_green);
      field_check("new_radius_blue",     want.new_radius_blue,     got.new_radius_blue);
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            pix_valid;
  logic                            pix_ready;
  fdps_pkg::pix_t                  pix;
  logic                            res_valid;
  logic                            res_ready;
  fdps_pkg::res_t                  res;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [fdps_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [fdps_pkg::GAIN_W-1:0]     cfg_data;

  film_step_scoreboard sb = new();
  bit                  hold_req = 1'b0;
  int unsigned         cycle_count = 0;

  film_develop_pixel_step #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .pix      (pix),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Monitor. Everything is sampled right at the edge, so it sees the values the
  // block itself saw; the driver's updates for this edge land later.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (pix_valid && pix_ready) sb.note_pixel(pix);
      if (res_valid && res_ready) sb.check_result(res);
    end
  end

  // Result side back-pressure: random modes of random length, one of them a
  // fixed on/off pattern, plus a single long hold-off when the stimulus asks.
  initial begin
    int mode;
    int mode_left;
    int stall_left;
    bit hold_taken;
    mode       = 0;
    mode_left  = 0;
    stall_left = 0;
    hold_taken = 1'b0;
    res_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        case (mode)
          0:       res_ready <= 1'b1;
          1:       res_ready <= ($urandom_range(0, 99) < 60);
          2:       res_ready <= ($urandom_range(0, 3) == 0);
          default: res_ready <= ((mode_left % 4) != 0);
        endcase
      end
    end
  end

  // Random level with a random magnitude so that products land on every
  // scale, not just in saturation.
  function automatic logic [fdps_pkg::FIELD_W-1:0] rand_level();
    int          bits;
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      2:       return raw[fdps_pkg::FIELD_W-1:0];
      default: begin
        bits = $urandom_range(1, fdps_pkg::FIELD_W);
        raw  = raw & ((32'd1 << bits) - 1);
        return raw[fdps_pkg::FIELD_W-1:0];
      end
    endcase
  endfunction

  function automatic logic [fdps_pkg::FIELD_W-1:0] rand_salt();
    logic [fdps_pkg::FIELD_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       return 24'h7F_FFFF;
      1:       return 24'h80_0000;
      default: begin
        v = rand_level();
        if ($urandom_range(0, 1)) v = -v;
        return v;
      end
    endcase
  endfunction

  function automatic logic [fdps_pkg::GAIN_W-1:0] rand_gain();
    int bits;
    bits = $urandom_range(0, fdps_pkg::GAIN_W);
    if (bits == fdps_pkg::GAIN_W) return $urandom;
    return $urandom & ((32'd1 << bits) - 1);
  endfunction

  function automatic fdps_pkg::pix_t random_pixel();
    fdps_pkg::pix_t p;
    p.developer_level = rand_level();
    p.salt_red        = rand_salt();
    p.salt_green      = rand_salt();
    p.salt_blue       = rand_salt();
    p.radius_red      = rand_level();
    p.radius_green    = rand_level();
    p.radius_blue     = rand_level();
    p.crystals_red    = rand_level();
    p.crystals_green  = rand_level();
    p.crystals_blue   = rand_level();
    return p;
  endfunction

  // Same salt, radius and crystal count on all three layers.
  function automatic fdps_pkg::pix_t make_pixel(logic [fdps_pkg::FIELD_W-1:0] dev,
                                                logic [fdps_pkg::FIELD_W-1:0] salt,
                                                logic [fdps_pkg::FIELD_W-1:0] rad,
                                                logic [fdps_pkg::FIELD_W-1:0] cry);
    fdps_pkg::pix_t p;
    p.developer_level = dev;
    p.salt_red        = salt;
    p.salt_green      = salt;
    p.salt_blue       = salt;
    p.radius_red      = rad;
    p.radius_green    = rad;
    p.radius_blue     = rad;
    p.crystals_red    = cry;
    p.crystals_green  = cry;
    p.crystals_blue   = cry;
    return p;
  endfunction

  // One pixel request: valid goes up at this edge and stays until accepted.
  task automatic send_pixel(fdps_pkg::pix_t p);
    pix_valid <= 1'b1;
    pix       <= p;
    do @(posedge clk); while (!pix_ready);
  endtask

  task automatic idle_pixels(int n);
    if (n > 0) begin
      pix_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop offering pixels and wait for every outstanding result.
  task automatic drain_results();
    pix_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [fdps_pkg::CFG_IDX_W-1:0] idx,
                           logic [fdps_pkg::GAIN_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Only called with the pipe empty. Optionally follows up with a write to the
  // unused index, which must leave all three gains alone.
  task automatic load_gains(logic [fdps_pkg::GAIN_W-1:0] g, logic [fdps_pkg::GAIN_W-1:0] d,
                            logic [fdps_pkg::GAIN_W-1:0] s, bit junk);
    write_reg(fdps_pkg::REG_GROWTH_GAIN, g);
    write_reg(fdps_pkg::REG_DEVELOPER_GAIN, d);
    write_reg(fdps_pkg::REG_SALT_GAIN, s);
    if (junk) write_reg(REG_NONE, $urandom);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    fdps_pkg::pix_t corner_q[$];
    fdps_pkg::pix_t p;
    int             sent;
    int             burst;
    bit             paused;

    rst       <= 1'b1;
    pix_valid <= 1'b0;
    pix       <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners under growth 1.0, developer 0.5, salt 2.0
    load_gains(GAIN_ONE, 32'h0000_8000, 32'h0002_0000, 1'b1);
    corner_q.push_back(make_pixel(24'h00_0000, 24'h00_0000, 24'h00_0000, 24'h00_0000));
    corner_q.push_back(make_pixel(24'hFF_FFFF, 24'h7F_FFFF, 24'hFF_FFFF, 24'hFF_FFFF));
    corner_q.push_back(make_pixel(24'hFF_FFFF, 24'h80_0000, 24'hFF_FFFF, 24'hFF_FFFF));
    p = make_pixel(24'h01_0000, 24'h00_8000, 24'h00_4000, 24'h02_0000);
    p.salt_green = 24'h00_4000;
    p.salt_blue  = 24'hFF_E000;
    corner_q.push_back(p);
    // negative growth pulls radius under zero
    corner_q.push_back(make_pixel(24'h01_0000, 24'h80_0000, 24'h00_0100, 24'h01_0000));
    // consumption larger than developer left: clamps at zero
    corner_q.push_back(make_pixel(24'h00_0100, 24'h7F_FFFF, 24'h10_0000, 24'h10_0000));
    // salt overshoots below its range, then above it
    corner_q.push_back(make_pixel(24'hFF_FFFF, 24'h01_0000, 24'h10_0000, 24'h10_0000));
    corner_q.push_back(make_pixel(24'hFF_FFFF, 24'hFF_0000, 24'h10_0000, 24'h10_0000));
    corner_q.push_back(make_pixel(24'h00_0000, 24'h40_0000, 24'h08_0000, 24'h08_0000));
    corner_q.push_back(make_pixel(24'h02_0000, 24'h10_0000, 24'h03_0000, 24'h00_0000));
    // layers of opposite sign cancel in the developer sum
    p = make_pixel(24'h01_0000, 24'h01_0000, 24'h02_0000, 24'h01_0000);
    p.salt_green = 24'hFF_0000;
    p.salt_blue  = 24'h00_0000;
    corner_q.push_back(p);
    // one lsb negative: floor rounding
    corner_q.push_back(make_pixel(24'h00_0001, 24'hFF_FFFF, 24'h01_0000, 24'h01_0000));
    // radius already at max keeps growing: saturates
    corner_q.push_back(make_pixel(24'h01_0000, 24'h01_0000, 24'hFF_FFFF, 24'h00_0001));
    corner_q.push_back(make_pixel(24'hAA_AAAA, 24'hAA_AAAA, 24'hAA_AAAA, 24'hAA_AAAA));
    corner_q.push_back(make_pixel(24'h55_5555, 24'h55_5555, 24'h55_5555, 24'h55_5555));
    foreach (corner_q[i]) begin
      send_pixel(corner_q[i]);
      idle_pixels($urandom_range(0, 3));
    end
    drain_results();

    // Random phases. Gain sets: all zero, all max, unity, then random.
    // Phase 3 triggers the long receiver hold-off with the sender still
    // pushing; phase 4 pauses mid-stream for a full drain; phase 5 never idles.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       load_gains('0, '0, '0, 1'b1);
        1:       load_gains('1, '1, '1, 1'b1);
        2:       load_gains(GAIN_ONE, GAIN_ONE, GAIN_ONE, 1'b0);
        default: load_gains(rand_gain(), rand_gain(), rand_gain(), 1'($urandom_range(0, 1)));
      endcase
      if (ph == 3) hold_req = 1'b1;
      sent   = 0;
      paused = 1'b0;
      while (sent < PHASE_PIX) begin
        burst = $urandom_range(1, 24);
        repeat (burst) begin
          send_pixel(random_pixel());
          sent++;
        end
        if (ph == 4 && !paused && sent >= PHASE_PIX / 2) begin
          drain_results();
          paused = 1'b1;
        end else if (ph != 5) begin
          idle_pixels($urandom_range(0, 10));
        end
      end
      drain_results();
    end

    // Tail: catch any stray result after the last expected one.
    repeat (LATENCY * 4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
